// ----- sv/mtd_pkg.sv -----
// Package for the modal tile downscaler: widths, reset values, color key function,
// channel codes and the sequencer state type.
// No dependencies; used by every module of the block.
package mtd_pkg;

   localparam int MAX_FACTOR_DEF = 4;
   localparam int PIX_W = 24;
   localparam int CHAN_W = 8;
   localparam int VOTE_W = 5;
   localparam int FACTOR_W = 3;
   localparam int FEFF_W = 4;
   localparam int KEY_W = 15;
   localparam int KEY_DROP = 3;
   localparam int KEY_RED_POS = 10;
   localparam int KEY_GRN_POS = 5;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 3'd4;

   localparam logic [1:0] CH_RED = 2'd0;
   localparam logic [1:0] CH_GRN = 2'd1;
   localparam logic [1:0] CH_BLU = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_KEY,
      ST_CNT,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [KEY_W-1:0] color_key(input logic [PIX_W-1:0] p);
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      r = p[23:16];
      g = p[15:8];
      b = p[7:0];
      color_key = (KEY_W'(r >> KEY_DROP) << KEY_RED_POS)
                | (KEY_W'(g >> KEY_DROP) << KEY_GRN_POS)
                | KEY_W'(b >> KEY_DROP);
   endfunction

endpackage

// ----- sv/modal_tile_downscale.sv -----
// Top level of the modal tile downscaler: tile store, mode search sequencer, sums
// and output register. Depends on mtd_pkg and the serial divider mtd_div.
//
//   Channel   Ports                                  Direction
//   request   req_valid, req_stall, req_pix_rgb       in, one word per source pixel
//   response  rsp_valid, rsp_stall, rsp_out_rgb,      out, one word per finished tile
//             rsp_mode_votes
//   control   csr_wr_en, csr_wr_data                 in, tile factor register
//
// A pixel is taken only while the block loads a tile; a csr write stalls the request.
// After the last pixel of a tile with n pixels the sequencer makes n*(n+2) reads of the tile
// store for the key, count and sum passes, then runs three divisions at one quotient bit per
// cycle, one per channel, then moves the result to the output register.
// Reset is synchronous and active high; it empties the tile and sets the factor to 4.
// A stalled response holds the finished tile at the end of the search until it leaves.
module modal_tile_downscale
   import mtd_pkg::*;
#(
   parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pix_rgb,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_out_rgb,
   output logic [VOTE_W-1:0]    rsp_mode_votes,
   input  logic                 csr_wr_en,
   input  logic [FACTOR_W-1:0]  csr_wr_data
);

   localparam int CAP = MAX_FACTOR * MAX_FACTOR;
   localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int SUM_W = CHAN_W + CNT_W;

   state_type state_ff, state_in;

   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic                phase_ff, phase_in;
   logic [KEY_W-1:0]    ki_ff, ki_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [KEY_W-1:0]    best_ff, best_in;
   logic [CNT_W-1:0]    bestc_ff, bestc_in;
   logic [CNT_W-1:0]    tally_ff, tally_in;
   logic [SUM_W-1:0]    sum_ff [3];
   logic [SUM_W-1:0]    sum_in [3];
   logic [CHAN_W-1:0]   quo_ff [3];
   logic [CHAN_W-1:0]   quo_in [3];
   logic [1:0]          ch_ff, ch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_rgb_ff, rsp_rgb_in;
   logic [VOTE_W-1:0]   rsp_votes_ff, rsp_votes_in;

   logic [PIX_W-1:0]    mem [CAP];
   logic [PIX_W-1:0]    rdata_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;

   logic [FEFF_W-1:0]   f_raw;
   logic [FEFF_W-1:0]   f_eff;
   logic [2*FEFF_W-1:0] n_sq;
   logic [CNT_W-1:0]    n_pix;
   logic [CNT_W-1:0]    last_idx;
   logic [KEY_W-1:0]    rkey;
   logic [CNT_W-1:0]    cnt_next;
   logic                req_take;
   logic                rsp_free;
   logic                div_start;
   logic [SUM_W-1:0]    div_num;
   logic [SUM_W-1:0]    div_quo;
   div_status_type      div_status;

   always_comb begin
      f_raw = {1'b0, factor_ff};
      f_eff = f_raw;
      if (f_raw == '0) begin
         f_eff = FEFF_W'(1);
      end else if (f_raw > FEFF_W'(MAX_FACTOR)) begin
         f_eff = FEFF_W'(MAX_FACTOR);
      end
      n_sq = {{FEFF_W{1'b0}}, f_eff} * {{FEFF_W{1'b0}}, f_eff};
      n_pix = CNT_W'(n_sq);
      last_idx = n_pix - 1'b1;
   end

   assign req_stall = (state_ff != ST_LOAD) || csr_wr_en;
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rkey = color_key(rdata_ff);
   assign wr_en = req_take && !csr_wr_en;

   always_comb begin
      state_in = state_ff;
      factor_in = factor_ff;
      fill_in = fill_ff;
      i_in = i_ff;
      j_in = j_ff;
      phase_in = phase_ff;
      ki_in = ki_ff;
      cnt_in = cnt_ff;
      best_in = best_ff;
      bestc_in = bestc_ff;
      tally_in = tally_ff;
      sum_in = sum_ff;
      quo_in = quo_ff;
      ch_in = ch_ff;
      rsp_rgb_in = rsp_rgb_ff;
      rsp_votes_in = rsp_votes_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start = 1'b0;
      rd_addr = (state_ff == ST_KEY) ? i_ff[ADDR_W-1:0] : j_ff[ADDR_W-1:0];
      cnt_next = cnt_ff + CNT_W'(rkey == ki_ff);
      case (ch_ff)
         CH_RED:  div_num = sum_ff[0];
         CH_GRN:  div_num = sum_ff[1];
         default: div_num = sum_ff[2];
      endcase

      case (state_ff)
         ST_LOAD: begin
            if (csr_wr_en) begin
               factor_in = csr_wr_data;
               fill_in = '0;
            end else if (req_take) begin
               if (fill_ff == last_idx) begin
                  fill_in = '0;
                  i_in = '0;
                  phase_in = 1'b0;
                  bestc_in = '0;
                  best_in = '0;
                  state_in = ST_KEY;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_KEY: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               ki_in = rkey;
               j_in = '0;
               cnt_in = '0;
               state_in = ST_CNT;
            end
         end
         ST_CNT: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               cnt_in = cnt_next;
               j_in = j_ff + 1'b1;
               if (j_ff == last_idx) begin
                  if (cnt_next > bestc_ff) begin
                     bestc_in = cnt_next;
                     best_in = ki_ff;
                  end
                  if (i_ff == last_idx) begin
                     j_in = '0;
                     tally_in = '0;
                     sum_in[0] = '0;
                     sum_in[1] = '0;
                     sum_in[2] = '0;
                     state_in = ST_SUM;
                  end else begin
                     i_in = i_ff + 1'b1;
                     state_in = ST_KEY;
                  end
               end
            end
         end
         ST_SUM: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (rkey == best_ff) begin
                  sum_in[0] = sum_ff[0] + SUM_W'(rdata_ff[23:16]);
                  sum_in[1] = sum_ff[1] + SUM_W'(rdata_ff[15:8]);
                  sum_in[2] = sum_ff[2] + SUM_W'(rdata_ff[7:0]);
                  tally_in = tally_ff + 1'b1;
               end
               j_in = j_ff + 1'b1;
               if (j_ff == last_idx) begin
                  ch_in = CH_RED;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!phase_ff) begin
               div_start = 1'b1;
               phase_in = 1'b1;
            end else if (div_status.done) begin
               phase_in = 1'b0;
               case (ch_ff)
                  CH_RED: begin
                     quo_in[0] = div_quo[CHAN_W-1:0];
                     ch_in = CH_GRN;
                  end
                  CH_GRN: begin
                     quo_in[1] = div_quo[CHAN_W-1:0];
                     ch_in = CH_BLU;
                  end
                  default: begin
                     quo_in[2] = div_quo[CHAN_W-1:0];
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rgb_in = {quo_ff[0], quo_ff[1], quo_ff[2]};
               rsp_votes_in = VOTE_W'(bestc_ff);
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         factor_ff <= FACTOR_RESET;
         fill_ff <= '0;
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         factor_ff <= factor_in;
         fill_ff <= fill_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      ki_ff <= ki_in;
      cnt_ff <= cnt_in;
      best_ff <= best_in;
      bestc_ff <= bestc_in;
      tally_ff <= tally_in;
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      ch_ff <= ch_in;
      rsp_rgb_ff <= rsp_rgb_in;
      rsp_votes_ff <= rsp_votes_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[ADDR_W-1:0]] <= req_pix_rgb;
      end
      rdata_ff <= mem[rd_addr];
   end

   mtd_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (bestc_ff),
      .status (div_status),
      .quo    (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_rgb = rsp_rgb_ff;
   assign rsp_mode_votes = rsp_votes_ff;

   a_fill_in_tile: assert property (@(posedge clock) disable iff (reset)
      fill_ff < n_pix)
      else $error("tile fill count reached the tile size");

   a_tally_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && state_in == ST_DIV) |=> (tally_ff == bestc_ff && bestc_ff != '0))
      else $error("sum pass count differs from the mode vote count");

   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_DIV)
      else $error("divider busy outside the division phase");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(state_ff) == ST_OUT)
      else $error("response word raised outside the output step");

endmodule

// ----- sv/mtd_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
// Depends on mtd_pkg for the status struct.
module mtd_div
   import mtd_pkg::*;
#(
   parameter int NUM_W = 13,
   parameter int DEN_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output div_status_type       status,
   output logic [NUM_W-1:0]     quo
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    trial;
   logic              fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits = trial >= {1'b0, den};
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         quo_in = num;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DEN_W'(trial - {1'b0, den});
         end else begin
            rem_in = trial[DEN_W-1:0];
         end
         quo_in = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo = quo_ff;

endmodule

// ----- tb/modal_tile_downscale_tb.sv -----
// Testbench for modal_tile_downscale: feeds tiles at set and random tile factors and checks
// each averaged dominant color and vote count against a tile model kept in this file.
// Depends on mtd_pkg and the RTL of the block.
module modal_tile_downscale_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mtd_pkg::*;

   localparam int TILE_MAX = MAX_FACTOR_DEF;
   localparam int TILE_CAP = TILE_MAX * TILE_MAX;
   localparam int SEARCH_WAIT = 800;
   localparam int RANDOM_PIXELS = 700;
   localparam int QUIET_TAIL = 120;

   typedef struct packed {
      logic [PIX_W-1:0]  rgb;
      logic [VOTE_W-1:0] votes;
   } tile_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [PIX_W-1:0]    req_pix_rgb;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [PIX_W-1:0]    rsp_out_rgb;
   logic [VOTE_W-1:0]   rsp_mode_votes;
   logic                csr_wr_en;
   logic [FACTOR_W-1:0] csr_wr_data;

   logic [PIX_W-1:0]    tile_pixels [TILE_CAP];
   int unsigned         pixels_in_tile;
   logic [FACTOR_W-1:0] factor_reg;
   tile_result_type     pending_tiles [$];
   bit                  idle_on;
   int                  stall_left;
   int                  mismatches;
   int                  pixels_sent;
   int                  tiles_checked;
   int                  factor_writes;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   modal_tile_downscale uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pix_rgb    (req_pix_rgb),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_rgb    (rsp_out_rgb),
      .rsp_mode_votes (rsp_mode_votes),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   function automatic logic [14:0] pixel_key(input logic [PIX_W-1:0] p);
      return {p[23:19], p[15:11], p[7:3]};
   endfunction

   // Adds one pixel to the current tile and, when the tile is full, queues its mode color.
   function automatic void absorb_pixel(input logic [PIX_W-1:0] pix);
      int unsigned     side;
      int unsigned     area;
      int unsigned     votes;
      int unsigned     top_votes;
      int unsigned     sum_r;
      int unsigned     sum_g;
      int unsigned     sum_b;
      int unsigned     hits;
      int              i;
      int              j;
      logic [14:0]     top_key;
      tile_result_type res;
      if (factor_reg == 0) begin
         side = 1;
      end else if (factor_reg > TILE_MAX) begin
         side = TILE_MAX;
      end else begin
         side = factor_reg;
      end
      area = side * side;
      if (pixels_in_tile >= area) begin
         pixels_in_tile = 0;
      end
      tile_pixels[pixels_in_tile] = pix;
      pixels_in_tile++;
      if (pixels_in_tile < area) begin
         return;
      end
      pixels_in_tile = 0;
      top_votes = 0;
      top_key = '0;
      for (i = 0; i < area; i++) begin
         votes = 0;
         for (j = 0; j < area; j++) begin
            if (pixel_key(tile_pixels[j]) == pixel_key(tile_pixels[i])) begin
               votes++;
            end
         end
         if (votes > top_votes) begin
            top_votes = votes;
            top_key = pixel_key(tile_pixels[i]);
         end
      end
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      hits = 0;
      for (i = 0; i < area; i++) begin
         if (pixel_key(tile_pixels[i]) == top_key) begin
            sum_r += tile_pixels[i][23:16];
            sum_g += tile_pixels[i][15:8];
            sum_b += tile_pixels[i][7:0];
            hits++;
         end
      end
      res.rgb = {8'(sum_r / hits), 8'(sum_g / hits), 8'(sum_b / hits)};
      res.votes = VOTE_W'(top_votes);
      pending_tiles.push_back(res);
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_pix_rgb <= PIX_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pix_rgb <= pix;
      do @(posedge clock); while (req_stall);
      absorb_pixel(pix);
      pixels_sent++;
   endtask

   task automatic drain_tiles();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tiles.size() != 0) @(negedge clock);
      repeat (SEARCH_WAIT) @(negedge clock);
   endtask

   task automatic set_factor(input logic [FACTOR_W-1:0] value);
      drain_tiles();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      factor_reg = value;
      pixels_in_tile = 0;
      factor_writes++;
   endtask

   // A partial tile at the reset factor is dropped by the write, and factor 7 clamps to 4.
   task automatic test_factor_override();
      int i;
      send_pixel(24'h123456);
      send_pixel(24'hFEDCBA);
      send_pixel(24'h808080);
      set_factor(3'd7);
      for (i = 0; i < TILE_CAP; i++) begin
         send_pixel({5'h1F, 3'(i), 5'h00, 3'(i + 1), 5'h15, 3'(i * 3)});
      end
   endtask

   // With factor 1 and factor 0 every word is a tile of its own.
   task automatic test_unit_tiles();
      set_factor(3'd1);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      set_factor(3'd0);
      send_pixel(24'hA5C35A);
   endtask

   // Two keys with two votes each; the key seen first must win.
   task automatic test_mode_tie();
      set_factor(3'd2);
      send_pixel(24'h070707);
      send_pixel(24'hF8F8F8);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
   endtask

   // Phases at random factors, mostly pixels drawn from a few shades so that keys repeat.
   task automatic test_random_tiles();
      logic [PIX_W-1:0] palette [4];
      logic [PIX_W-1:0] pix;
      int               shades;
      int               batch;
      int               k;
      int               sent_here;
      sent_here = 0;
      while (sent_here < RANDOM_PIXELS) begin
         set_factor(FACTOR_W'($urandom_range(0, 7)));
         idle_on = (sent_here < RANDOM_PIXELS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         shades = $urandom_range(1, 4);
         for (k = 0; k < 4; k++) begin
            palette[k] = PIX_W'($urandom);
         end
         if ($urandom_range(0, 4) == 0) begin
            palette[0] = 24'h000000;
         end
         if ($urandom_range(0, 4) == 0) begin
            palette[shades - 1] = 24'hFFFFFF;
         end
         batch = $urandom_range(8, 48);
         for (k = 0; k < batch; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               pix = PIX_W'($urandom);
            end else begin
               pix = (palette[$urandom_range(0, shades - 1)] & 24'hF8F8F8)
                   | (PIX_W'($urandom) & 24'h070707);
            end
            send_pixel(pix);
         end
         sent_here += batch;
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      tile_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tiles.size() == 0) begin
            $display("%0t: unexpected word, out_rgb %06h mode_votes %0d",
                     $time, rsp_out_rgb, rsp_mode_votes);
            mismatches++;
         end else begin
            want = pending_tiles.pop_front();
            tiles_checked++;
            if (rsp_out_rgb !== want.rgb) begin
               $display("%0t: out_rgb expected %06h, got %06h", $time, want.rgb, rsp_out_rgb);
               mismatches++;
            end
            if (rsp_mode_votes !== want.votes) begin
               $display("%0t: mode_votes expected %0d, got %0d",
                        $time, want.votes, rsp_mode_votes);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pix_rgb = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      factor_reg = FACTOR_RESET;
      pixels_in_tile = 0;
      idle_on = 1'b1;
      mismatches = 0;
      pixels_sent = 0;
      tiles_checked = 0;
      factor_writes = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_factor_override();
      test_unit_tiles();
      test_mode_tie();
      test_random_tiles();
      idle_on = 1'b0;
      drain_tiles();
      $display("tb: %0d pixels sent, %0d tiles checked across %0d tile factor writes",
               pixels_sent, tiles_checked, factor_writes);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
